FILE: rtl/xfpr_pkg.sv
package xfpr_pkg;

  localparam int MAX_PAYLOAD  = 8192;
  localparam int HEADER_BYTES = 4;
  localparam int KEY_LENGTH   = 11;

  localparam logic [15:0] MAX_LENGTH  = 16'(MAX_PAYLOAD + HEADER_BYTES);
  localparam logic [7:0]  CHAIN_SEED  = 8'd118;
  localparam logic [7:0]  PICK_CHAIN  = 8'h13;
  localparam logic [7:0]  PICK_KEY    = 8'h14;
  localparam logic [7:0]  TYPE_ONE    = 8'd1;

  localparam int POS_W  = 14;
  localparam int IDX_W  = 13;
  localparam int FLEN_W = 14;
  localparam int KIDX_W = 4;

  localparam logic [POS_W-1:0] POS_LEN_LO  = POS_W'(0);
  localparam logic [POS_W-1:0] POS_LEN_HI  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_TYPE_LO = POS_W'(2);
  localparam logic [POS_W-1:0] POS_TYPE_HI = POS_W'(3);

  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 4;

  typedef enum logic [1:0] {
    CIPHER_NONE  = 2'd0,
    CIPHER_CHAIN = 2'd1,
    CIPHER_KEY   = 2'd2
  } cipher_t;

  typedef struct packed {
    logic              length_error;
    cipher_t           cipher_used;
    logic              empty_frame;
    logic              last_byte;
    logic [FLEN_W-1:0] frame_length;
    logic [IDX_W-1:0]  byte_index;
    logic [7:0]        out_byte;
  } result_t;

  function automatic logic [7:0] key_byte(input logic [KIDX_W-1:0] idx);
    logic [7:0] k;
    case (idx)
      4'd0:    k = "q";
      4'd1:    k = "m";
      4'd2:    k = "f";
      4'd3:    k = "a";
      4'd4:    k = "k";
      4'd5:    k = "t";
      4'd6:    k = "n";
      4'd7:    k = "p";
      4'd8:    k = "g";
      4'd9:    k = "j";
      4'd10:   k = "s";
      default: k = "q";
    endcase
    return k;
  endfunction

endpackage

FILE: rtl/xfpr_core.sv
module xfpr_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        rx_byte,
  input  logic              restart,
  output logic              res_valid,
  output xfpr_pkg::result_t res
);

  logic [xfpr_pkg::POS_W-1:0]  frame_position, frame_position_next, pos_e;
  logic [15:0]                 length_field, length_field_next, len_e;
  logic [7:0]                  cipher_type_low, cipher_type_low_next, ctl_e;
  logic                        type_is_one, type_is_one_next, t1_e;
  logic                        encrypted_link, encrypted_link_next, enc_e;
  xfpr_pkg::cipher_t           cipher_choice, cipher_choice_next, ch_e;
  logic [7:0]                  previous_cipher_byte, previous_cipher_byte_next, prev_e;
  logic [xfpr_pkg::KIDX_W-1:0] key_index, key_index_next, ki_e;

  logic [xfpr_pkg::POS_W-1:0]  idx;
  logic [xfpr_pkg::KIDX_W-1:0] ki_use;
  logic [7:0]                  prev_use, k;
  logic                        last;

  // A restart flag makes the item see the reset state before it is processed.
  always_comb begin
    pos_e  = restart ? '0 : frame_position;
    len_e  = restart ? '0 : length_field;
    ctl_e  = restart ? '0 : cipher_type_low;
    t1_e   = restart ? 1'b0 : type_is_one;
    enc_e  = restart ? 1'b0 : encrypted_link;
    ch_e   = restart ? xfpr_pkg::CIPHER_NONE : cipher_choice;
    prev_e = restart ? '0 : previous_cipher_byte;
    ki_e   = restart ? '0 : key_index;
  end

  always_comb begin
    frame_position_next       = pos_e;
    length_field_next         = len_e;
    cipher_type_low_next      = ctl_e;
    type_is_one_next          = t1_e;
    encrypted_link_next       = enc_e;
    cipher_choice_next        = ch_e;
    previous_cipher_byte_next = prev_e;
    key_index_next            = ki_e;
    res_valid                 = 1'b0;
    res                       = '0;
    res.frame_length          = len_e[xfpr_pkg::FLEN_W-1:0];
    idx                       = pos_e - xfpr_pkg::POS_W'(xfpr_pkg::HEADER_BYTES);
    last                      = ({2'b00, pos_e} + 16'd1) == len_e;
    ki_use                    = ki_e;
    prev_use                  = prev_e;
    k                         = 8'd0;
    case (pos_e)
      xfpr_pkg::POS_LEN_LO: begin
        length_field_next   = {8'd0, rx_byte};
        frame_position_next = xfpr_pkg::POS_LEN_HI;
      end
      xfpr_pkg::POS_LEN_HI: begin
        length_field_next   = {rx_byte, len_e[7:0]};
        frame_position_next = xfpr_pkg::POS_TYPE_LO;
      end
      xfpr_pkg::POS_TYPE_LO: begin
        cipher_type_low_next = rx_byte;
        frame_position_next  = xfpr_pkg::POS_TYPE_HI;
      end
      xfpr_pkg::POS_TYPE_HI: begin
        type_is_one_next = (ctl_e == xfpr_pkg::TYPE_ONE) && (rx_byte == 8'd0);
        if (len_e[15] || len_e < 16'(xfpr_pkg::HEADER_BYTES) ||
            len_e > xfpr_pkg::MAX_LENGTH) begin
          frame_position_next = '0;
          res_valid           = 1'b1;
          res.length_error    = 1'b1;
        end else if (len_e == 16'(xfpr_pkg::HEADER_BYTES)) begin
          if (type_is_one_next && ch_e == xfpr_pkg::CIPHER_NONE) begin
            encrypted_link_next = 1'b1;
          end
          frame_position_next = '0;
          res_valid           = 1'b1;
          res.last_byte       = 1'b1;
          res.empty_frame     = 1'b1;
        end else begin
          frame_position_next = xfpr_pkg::POS_W'(xfpr_pkg::HEADER_BYTES);
        end
      end
      default: begin
        // The first payload byte may pick the cipher for the whole connection.
        if (idx == '0) begin
          ki_use   = '0;
          prev_use = '0;
          if (t1_e && ch_e == xfpr_pkg::CIPHER_NONE) begin
            encrypted_link_next = 1'b1;
            if (rx_byte == xfpr_pkg::PICK_CHAIN) begin
              cipher_choice_next = xfpr_pkg::CIPHER_CHAIN;
            end else if (rx_byte == xfpr_pkg::PICK_KEY) begin
              cipher_choice_next = xfpr_pkg::CIPHER_KEY;
            end
          end
        end
        k            = xfpr_pkg::key_byte(ki_use);
        res.out_byte = rx_byte;
        if (t1_e && cipher_choice_next == xfpr_pkg::CIPHER_CHAIN) begin
          res.out_byte    = rx_byte ^ ((idx == '0) ? xfpr_pkg::CHAIN_SEED : prev_use);
          res.cipher_used = xfpr_pkg::CIPHER_CHAIN;
        end else if (t1_e && cipher_choice_next == xfpr_pkg::CIPHER_KEY) begin
          if (rx_byte != 8'd0 && rx_byte != k) begin
            res.out_byte = rx_byte ^ k;
          end
          res.cipher_used = xfpr_pkg::CIPHER_KEY;
        end
        previous_cipher_byte_next = rx_byte;
        key_index_next = (ki_use == xfpr_pkg::KIDX_W'(xfpr_pkg::KEY_LENGTH - 1)) ?
                         '0 : ki_use + xfpr_pkg::KIDX_W'(1);
        frame_position_next = last ? '0 : pos_e + xfpr_pkg::POS_W'(1);
        res_valid      = 1'b1;
        res.byte_index = idx[xfpr_pkg::IDX_W-1:0];
        res.last_byte  = last;
      end
    endcase
    if (!accept) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position       <= '0;
      length_field         <= '0;
      cipher_type_low      <= '0;
      type_is_one          <= 1'b0;
      encrypted_link       <= 1'b0;
      cipher_choice        <= xfpr_pkg::CIPHER_NONE;
      previous_cipher_byte <= '0;
      key_index            <= '0;
    end else if (accept) begin
      frame_position       <= frame_position_next;
      length_field         <= length_field_next;
      cipher_type_low      <= cipher_type_low_next;
      type_is_one          <= type_is_one_next;
      encrypted_link       <= encrypted_link_next;
      cipher_choice        <= cipher_choice_next;
      previous_cipher_byte <= previous_cipher_byte_next;
      key_index            <= key_index_next;
    end
  end

endmodule

FILE: rtl/xfpr_out_reg.sv
module xfpr_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  xfpr_pkg::result_t push_data,
  output logic              can_push,
  output logic              out_valid,
  input  logic              out_ready,
  output xfpr_pkg::result_t out_data
);

  logic              skid_valid;
  xfpr_pkg::result_t skid_data;

  assign can_push = !skid_valid;

  // The skid entry catches a result that arrives while the output stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

FILE: rtl/xor_framed_packet_receiver.sv
// Throughput: one received byte per cycle while s_tready is high; header bytes give no transfer of
// their own, save the last on a length error or an empty frame. The two-entry output stage keeps
// s_tready high while one result waits to be taken, and drops it while the skid entry is full.
// Reset (rst, synchronous) clears the frame position, the cipher choice and the output stage.
// A restart byte first clears the frame position and the cipher choice, then opens a new connection.
module xor_framed_packet_receiver (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // rx_byte
  input  logic                            s_tuser,   // restart
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [xfpr_pkg::OUT_DATA_W-1:0] m_tdata,   // out_byte, byte_index, frame_length, zero fill
  output logic [xfpr_pkg::OUT_USER_W-1:0] m_tuser,   // empty_frame, cipher_used, length_error
  output logic                            m_tlast    // last_byte
);

  logic              accept;
  logic              res_valid;
  xfpr_pkg::result_t res;
  xfpr_pkg::result_t out_data;

  assign accept = s_tvalid && s_tready;

  xfpr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (s_tdata),
    .restart   (s_tuser),
    .res_valid (res_valid),
    .res       (res)
  );

  xfpr_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .can_push  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data)
  );

  assign m_tdata = {5'd0, out_data.frame_length, out_data.byte_index, out_data.out_byte};
  assign m_tuser = {out_data.length_error, out_data.cipher_used, out_data.empty_frame};
  assign m_tlast = out_data.last_byte;

endmodule
